[sv/ogfq_pkg.sv]
// ----------------------------------------------------------------------------
// ogfq_pkg
// Shared constants and command/status types for the gap fit query unit.
// ----------------------------------------------------------------------------
package ogfq_pkg;
   localparam int MAX_POS = 1024;
   localparam int PW      = 11;
   localparam int AW      = 10;

   localparam logic FUNC_PLACE = 1'b0;
   localparam logic FUNC_ASK   = 1'b1;

   typedef struct packed {
      logic          clear_start;
      logic          place_start;
      logic          ask_start;
      logic [PW-1:0] position;
      logic [PW-1:0] block_size;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic has_result;
      logic fits;
   } status_type;
endpackage

[sv/ogfq_datapath.sv]
// ----------------------------------------------------------------------------
// ogfq_datapath
// Free-run memory and obstacle memory. A place scans left for the previous
// obstacle then rewrites runs over [prev, pos); an ask scans starts in order.
// ----------------------------------------------------------------------------
module ogfq_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ogfq_pkg::cmd_type    cmd,
   output ogfq_pkg::status_type status
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLR   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_ASK   = 3'd4;
   localparam logic [2:0] S_CHK   = 3'd5;

   logic [ogfq_pkg::PW-1:0] run_mem [ogfq_pkg::MAX_POS];
   logic                    obs_mem [ogfq_pkg::MAX_POS];

   logic [2:0]              state_ff, state_in;
   logic [ogfq_pkg::PW-1:0] idx_ff, idx_in, pos_ff, pos_in, sz_ff, sz_in, lim_ff, lim_in;
   logic                    done_ff, done_in, res_ff, res_in, fits_ff, fits_in;
   logic [ogfq_pkg::PW-1:0] run_rd_ff, run_wd, span;
   logic                    obs_rd_ff, run_we, obs_we;
   logic [ogfq_pkg::AW-1:0] a, rd_addr;

   // read address runs one step ahead so the registered data matches idx_ff
   assign a       = idx_ff[ogfq_pkg::AW-1:0];
   assign rd_addr = idx_in[ogfq_pkg::AW-1:0];
   assign span    = cmd.position - cmd.block_size;
   assign run_we  = (state_ff == S_CLR) || (state_ff == S_WRITE);
   assign run_wd  = (state_ff == S_CLR) ? ogfq_pkg::PW'(ogfq_pkg::MAX_POS) - idx_ff :
                                          pos_ff - idx_ff;
   assign obs_we  = (state_ff == S_CLR) || ((state_ff == S_CHK) && !obs_rd_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      sz_in    = sz_ff;
      lim_in   = lim_ff;
      res_in   = res_ff;
      fits_in  = fits_ff;
      done_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pos_in  = cmd.position;
            sz_in   = cmd.block_size;
            fits_in = 1'b0;
            if (cmd.clear_start) begin
               state_in = S_CLR;
               idx_in   = '0;
            end else if (cmd.place_start) begin
               res_in = 1'b0;
               if (cmd.position >= ogfq_pkg::PW'(ogfq_pkg::MAX_POS)) done_in = 1'b1;
               else begin
                  state_in = S_CHK;
                  idx_in   = cmd.position;
               end
            end else if (cmd.ask_start) begin
               res_in = 1'b1;
               if (cmd.block_size > cmd.position) done_in = 1'b1;
               else begin
                  state_in = S_ASK;
                  idx_in   = '0;
                  lim_in   = (span > ogfq_pkg::PW'(ogfq_pkg::MAX_POS - 1)) ?
                             ogfq_pkg::PW'(ogfq_pkg::MAX_POS - 1) : span;
               end
            end
         end
         S_CLR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == ogfq_pkg::PW'(ogfq_pkg::MAX_POS - 1)) state_in = S_IDLE;
         end
         S_CHK: begin
            if (obs_rd_ff || idx_ff == '0) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = S_SCAN;
               idx_in   = idx_ff - 1'b1;
            end
         end
         S_SCAN: begin
            if (idx_ff == '0 || obs_rd_ff) state_in = S_WRITE;
            else idx_in = idx_ff - 1'b1;
         end
         S_WRITE: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= pos_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         S_ASK: begin
            if (run_rd_ff >= sz_ff) begin
               fits_in  = 1'b1;
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else if (idx_ff == lim_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
         pos_ff   <= '0;
         sz_ff    <= '0;
         lim_ff   <= '0;
         res_ff   <= 1'b0;
         fits_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         sz_ff    <= sz_in;
         lim_ff   <= lim_in;
         res_ff   <= res_in;
         fits_ff  <= fits_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run_we) run_mem[a] <= run_wd;
      if (obs_we) obs_mem[a] <= (state_ff == S_CHK);
      run_rd_ff <= run_mem[rd_addr];
      obs_rd_ff <= obs_mem[rd_addr];
   end

   assign status.busy       = (state_ff != S_IDLE);
   assign status.done       = done_ff;
   assign status.has_result = res_ff;
   assign status.fits       = fits_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == S_IDLE) else $error("done while busy");
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> idx_ff < pos_ff) else $error("write past pos");
   a_ask_lim: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ASK |-> idx_ff <= lim_ff) else $error("ask past limit");
endmodule

[sv/ogfq_ctrl.sv]
// ----------------------------------------------------------------------------
// ogfq_ctrl
// Handshake controller: issues one command per transfer, holds the result.
// ----------------------------------------------------------------------------
module ogfq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [10:0]          req_position,
   input  logic [10:0]          req_block_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_fits,
   output ogfq_pkg::cmd_type    cmd,
   input  ogfq_pkg::status_type status
);
   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_WAIT = 2'd1;

   logic [1:0] state_ff;
   logic       rv_ff, rf_ff, go;

   assign req_ready = (state_ff == C_IDLE) && !status.busy && !rv_ff;
   assign go        = req_valid && req_ready;
   assign cmd.clear_start = 1'b0;
   assign cmd.place_start = go && (req_func == ogfq_pkg::FUNC_PLACE);
   assign cmd.ask_start   = go && (req_func == ogfq_pkg::FUNC_ASK);
   assign cmd.position    = req_position;
   assign cmd.block_size  = req_block_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         case (state_ff)
            C_IDLE: if (go) state_ff <= C_WAIT;
            C_WAIT: if (status.done) begin
               state_ff <= C_IDLE;
               if (status.has_result) begin
                  rv_ff <= 1'b1;
                  rf_ff <= status.fits;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_fits  = rf_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      go |=> state_ff == C_WAIT) else $error("command lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fits))
      else $error("result dropped");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("accept with result pending");
endmodule

[sv/obstacle_gap_fit_query_unit.sv]
// ----------------------------------------------------------------------------
// obstacle_gap_fit_query_unit
// Ask: answered without a scan when size exceeds position, else after checking
// starts in order up to the first fit or the limit, at most MAX_POS starts.
// Place: ready again without a scan if out of range, repeated or at zero, else
// after scanning left to the previous obstacle and rewriting runs up to pos.
// One item at a time; the next transfer waits until any result has been taken.
// Reset: synchronous; a clearing pass of all entries follows, req_ready low.
// ----------------------------------------------------------------------------
module obstacle_gap_fit_query_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [10:0] req_position,
   input  logic [10:0] req_block_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fits
);
   ogfq_pkg::cmd_type    cmd;
   ogfq_pkg::status_type status;

   ogfq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_position,
      .req_block_size, .rsp_valid, .rsp_ready, .rsp_fits, .cmd, .status
   );

   ogfq_datapath u_dp (.clock, .reset, .cmd, .status);
endmodule
